/* src/skoi_pkg.sv */
// Shared types and constants for the sorted key offset index unit.
package skoi_pkg;

  // Fixed payload widths
  localparam int unsigned KeyW = 64;
  localparam int unsigned OffW = 64;
  localparam int unsigned PosW = 10;
  localparam int unsigned OpW  = 2;

  // Depth of the command and result queues
  localparam int unsigned QueueDepth = 2;

  // Operation codes on the input port
  localparam logic [OpW-1:0] OP_APPEND = 2'd0;
  localparam logic [OpW-1:0] OP_FIND   = 2'd1;
  localparam logic [OpW-1:0] OP_GET    = 2'd2;

  // Classified command handed from the front to the back
  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_FIND,
    CMD_GET,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [KeyW-1:0] key;
    logic [OffW-1:0] offset;
    logic [PosW-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] match_position;
    logic [OffW-1:0] match_offset;
    logic [KeyW-1:0] key_out;
    logic            full_drop;
  } res_t;

endpackage

/* src/skoi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module skoi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/skoi_fifo.sv */
// Small synchronous queue used between front, back and result port.
module skoi_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* src/skoi_front.sv */
// Front end: accepts items and classifies the opcode into a command.
module skoi_front (
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [skoi_pkg::OpW-1:0]          op_i,
  input  logic [skoi_pkg::KeyW-1:0]         key_i,
  input  logic [skoi_pkg::OffW-1:0]         offset_i,
  input  logic [skoi_pkg::PosW-1:0]         position_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output skoi_pkg::cmd_t                    cmd_o
);
  import skoi_pkg::*;

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  // Opcode decode; the unused code becomes a no-op
  always_comb begin
    cmd_o.key      = key_i;
    cmd_o.offset   = offset_i;
    cmd_o.position = position_i;
    unique case (op_i)
      OP_APPEND: cmd_o.cmd = CMD_APPEND;
      OP_FIND:   cmd_o.cmd = CMD_FIND;
      OP_GET:    cmd_o.cmd = CMD_GET;
      default:   cmd_o.cmd = CMD_NOP;
    endcase
  end

endmodule

/* src/skoi_back.sv */
// Back end: owns the key and offset memories and runs append, find and get.
module skoi_back #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  skoi_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output skoi_pkg::res_t res_o
);
  import skoi_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINAL,
    ST_GET
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   base_q, base_d;
  logic [CW-1:0]   span_q, span_d;
  logic [AW-1:0]   at_q, at_d;
  logic [KeyW-1:0] probe_q, probe_d;

  logic            mem_we;
  logic [AW-1:0]   mem_raddr;
  logic [KeyW-1:0] key_rd;
  logic [OffW-1:0] off_rd;

  logic [CW-1:0]   half;
  logic [AW-1:0]   nb;
  logic [CW-1:0]   ns;
  logic [CW-1:0]   sum_w;
  logic [31:0]     pos_ext;
  logic [31:0]     base_ext;

  // First probe position of a search over the whole table
  function automatic logic [AW-1:0] half_of_count(input logic [CW-1:0] cnt);
    logic [CW-1:0] h;
    h = cnt >> 1;
    return h[AW-1:0];
  endfunction

  skoi_ram #(.WIDTH(KeyW), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(cmd_i.key),
    .raddr_i(mem_raddr),
    .rdata_o(key_rd)
  );

  skoi_ram #(.WIDTH(OffW), .DEPTH(TABLE_DEPTH)) u_off_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(cmd_i.offset),
    .raddr_i(mem_raddr),
    .rdata_o(off_rd)
  );

  assign half     = span_q >> 1;
  assign pos_ext  = 32'(cmd_i.position);
  assign base_ext = 32'(base_q);

  // Search step: narrow the range by the key read last cycle
  always_comb begin
    if (probe_q < key_rd) begin
      nb = base_q;
      ns = half;
    end else begin
      nb = at_q;
      ns = span_q - half;
    end
    sum_w = CW'(nb) + (ns >> 1);
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    base_d     = base_q;
    span_d     = span_q;
    at_d       = at_q;
    probe_d    = probe_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    mem_we     = 1'b0;
    mem_raddr  = at_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.cmd)
            CMD_APPEND: begin
              res_push_o = 1'b1;
              if (count_q == CW'(TABLE_DEPTH)) begin
                res_o.full_drop = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            CMD_FIND: begin
              if (count_q == '0) begin
                res_push_o = 1'b1;
              end else begin
                probe_d = cmd_i.key;
                base_d  = '0;
                span_d  = count_q;
                if (count_q > CW'(1)) begin
                  at_d      = half_of_count(count_q);
                  mem_raddr = half_of_count(count_q);
                  state_d   = ST_SEARCH;
                end else begin
                  mem_raddr = '0;
                  state_d   = ST_FINAL;
                end
              end
            end
            CMD_GET: begin
              if (pos_ext < 32'(count_q)) begin
                mem_raddr = pos_ext[AW-1:0];
                state_d   = ST_GET;
              end else begin
                res_push_o = 1'b1;
              end
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        base_d = nb;
        span_d = ns;
        if (ns > CW'(1)) begin
          at_d      = sum_w[AW-1:0];
          mem_raddr = sum_w[AW-1:0];
        end else begin
          mem_raddr = nb;
          state_d   = ST_FINAL;
        end
      end
      ST_FINAL: begin
        res_push_o = 1'b1;
        if (key_rd == probe_q) begin
          res_o.found          = 1'b1;
          res_o.match_position = base_ext[PosW-1:0];
          res_o.match_offset   = off_rd;
        end
        state_d = ST_IDLE;
      end
      ST_GET: begin
        res_push_o    = 1'b1;
        res_o.key_out = key_rd;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      base_q  <= '0;
      span_q  <= '0;
      at_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      base_q  <= base_d;
      span_q  <= span_d;
      at_q    <= at_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
  end

`ifndef SYNTHESIS
  // A result is only produced when the result queue has room
  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  // Search steps only run on a range of two or more entries
  a_search_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (span_q > CW'(1)))
    else $error("search step on a span below two");

  // The final read lands inside the filled part of the table
  a_final_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |-> (CW'(base_q) < count_q))
    else $error("final entry beyond fill count");

  // Fill count only holds or grows by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1))
    else $error("fill count jumped");

  // Fill count never passes the table depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (count_q < CW'(TABLE_DEPTH)))
    else $error("append written into a full table");
`endif

endmodule

/* src/sorted_key_offset_index_unit.sv */
// Sorted key/offset index: a table of key and offset pairs with append, find and get.
// Items enter through a two-entry command queue and results leave through a
// two-entry result queue, so input and output stall independently. An append,
// a get past the end, an unused opcode and a find on an empty table are answered
// straight from the idle state; a get in the table reads the key memory and
// answers from the get state. A find issues its first read from the idle state,
// then the key memory's single registered read port gives one halving step of
// the search per cycle, and the final state compares the landing entry. Items
// are carried out one at a time in the back end. Keys are expected in ascending
// order; a full table drops an append and sets full_drop.
module sorted_key_offset_index_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [skoi_pkg::OpW-1:0]  op_i,
  input  logic [skoi_pkg::KeyW-1:0] key_i,
  input  logic [skoi_pkg::OffW-1:0] offset_i,
  input  logic [skoi_pkg::PosW-1:0] position_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      found_o,
  output logic [skoi_pkg::PosW-1:0] match_position_o,
  output logic [skoi_pkg::OffW-1:0] match_offset_o,
  output logic [skoi_pkg::KeyW-1:0] key_out_o,
  output logic                      full_drop_o
);
  import skoi_pkg::*;

  logic cq_push, cq_full, cq_pop, cq_empty;
  cmd_t cq_wdata, cq_rdata;
  logic rq_push, rq_full;
  res_t rq_wdata, rq_rdata;

  // Front: decode and enqueue
  skoi_front u_front (
    .push_i    (push),
    .full_o    (full),
    .op_i      (op_i),
    .key_i     (key_i),
    .offset_i  (offset_i),
    .position_i(position_i),
    .q_full_i  (cq_full),
    .q_push_o  (cq_push),
    .cmd_o     (cq_wdata)
  );

  // Command queue between front and back
  skoi_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(QueueDepth)) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cq_push),
    .wdata_i(cq_wdata),
    .full_o (cq_full),
    .pop_i  (cq_pop),
    .rdata_o(cq_rdata),
    .empty_o(cq_empty)
  );

  // Back: table memories and search sequencer
  skoi_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cq_empty),
    .cmd_i      (cq_rdata),
    .cmd_pop_o  (cq_pop),
    .res_full_i (rq_full),
    .res_push_o (rq_push),
    .res_o      (rq_wdata)
  );

  // Result queue toward the consumer
  skoi_fifo #(.WIDTH($bits(res_t)), .DEPTH(QueueDepth)) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rq_push),
    .wdata_i(rq_wdata),
    .full_o (rq_full),
    .pop_i  (pop),
    .rdata_o(rq_rdata),
    .empty_o(empty)
  );

  assign found_o          = rq_rdata.found;
  assign match_position_o = rq_rdata.match_position;
  assign match_offset_o   = rq_rdata.match_offset;
  assign key_out_o        = rq_rdata.key_out;
  assign full_drop_o      = rq_rdata.full_drop;

endmodule
